// File: rtl/mrw_pkg.sv
// Shared types and constants for the multi-range watchpoint unit.
`default_nettype none

package mrw_pkg;

  localparam int unsigned SLOTS      = 6;
  localparam int unsigned SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PHYS_W     = 28;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LEN_W      = 29;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_CHECK = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_STEP  = 2'd1,
    ST_BREAK = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_FIND,
    S_ADD_SPAN,
    S_ADD_SPREAD,
    S_CHK_SCAN,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic              watch_writes;
    logic              watch_reads;
    logic              access_is_write;
  } in_item_t;

  typedef struct packed {
    logic              slot_taken;
    logic [1:0]        status;
    logic [PHYS_W-1:0] cover_base;
    logic [PHYS_W-1:0] cover_mask;
    logic              watching;
  } out_item_t;

  // Slot table write port
  typedef struct packed {
    logic                  clr;
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [PHYS_W-1:0]     start;
    logic [ADDR_W-1:0]     stop;
  } slot_wr_t;

  // Two unsigned less-than compares per cycle: a0 < b0, a1 < b1
  typedef struct packed {
    logic [ADDR_W-1:0] a0;
    logic [ADDR_W-1:0] b0;
    logic [ADDR_W-1:0] a1;
    logic [ADDR_W-1:0] b1;
  } cmp_req_t;

  typedef struct packed {
    logic lt0;
    logic lt1;
  } cmp_rsp_t;

endpackage

`default_nettype wire

// File: rtl/multi_range_watchpoint_unit.sv
// Top level: sequencer, cover registers and beat handshakes of the watchpoint unit.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | in_valid_i / in_stall_o  | in_item_i  (in_item_t)
//  out     | output    | out_valid_o / out_stall_i| out_item_o (out_item_t)
//
// Clear and no-op beats go straight to the finish state; checks scan the slots
// only on a coarse cover hit; adds run the slot search, min/max span walk and
// mask loop (one bit per cycle); span, mask and check steps share one comparator.
// Reset empties the table and disables watching; no clearing pass.
// A finished result waits in the output register while the next beat runs;
// out_stall_i only holds the sequencer in its final state.
`default_nettype none

module multi_range_watchpoint_unit
  import mrw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  fsm_e                  state_q, state_d;
  logic [SLOT_IDX_W-1:0] idx_q, idx_d;
  logic [PHYS_W-1:0]     addr_q, addr_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic                  wr_q, wr_d;
  logic                  rd_q, rd_d;
  logic                  taken_q, taken_d;
  logic [1:0]            status_q, status_d;
  logic [ADDR_W-1:0]     lo_q, lo_d;
  logic [ADDR_W-1:0]     hi_q, hi_d;
  logic [ADDR_W-1:0]     spread_q, spread_d;
  logic [PHYS_W-1:0]     base_q, base_d;
  logic [PHYS_W-1:0]     mask_q, mask_d;
  logic                  trap_wr_q, trap_wr_d;
  logic                  trap_rd_q, trap_rd_d;
  logic                  enabled_q, enabled_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  slot_wr_t          tbl_wr;
  logic [PHYS_W-1:0] rd_start;
  logic [ADDR_W-1:0] rd_stop;
  cmp_req_t          cmp_req;
  cmp_rsp_t          cmp_rsp;

  logic              accept;
  logic              slot_free;
  logic              last_slot;
  logic              dir_ok;
  logic              coarse_hit;
  logic              out_load;
  logic [PHYS_W-1:0] addr_in;
  logic [ADDR_W-1:0] stop_val;

  mrw_slot_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (tbl_wr),
    .rd_idx_i   (idx_q),
    .rd_start_o (rd_start),
    .rd_stop_o  (rd_stop)
  );

  mrw_cmp_unit u_cmp (
    .req_i (cmp_req),
    .rsp_o (cmp_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign addr_in     = in_item_i.address[PHYS_W-1:0];
  assign dir_ok      = in_item_i.access_is_write ? trap_wr_q : trap_rd_q;
  assign coarse_hit  = enabled_q && dir_ok && ((addr_in & mask_q) == base_q);
  assign slot_free   = (rd_start == '0);
  assign last_slot   = (idx_q == SLOT_IDX_W'(SLOTS - 1));
  assign out_load    = !out_valid_q || !out_stall_i;
  // end address wraps modulo 2^32
  assign stop_val    = ADDR_W'({{(ADDR_W-PHYS_W){1'b0}}, addr_q})
                     + ADDR_W'({{(ADDR_W-LEN_W){1'b0}}, len_q})
                     - ADDR_W'(1);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    len_d       = len_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    taken_d     = taken_q;
    status_d    = status_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    spread_d    = spread_q;
    base_d      = base_q;
    mask_d      = mask_q;
    trap_wr_d   = trap_wr_q;
    trap_rd_d   = trap_rd_q;
    enabled_d   = enabled_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    tbl_wr      = '0;
    cmp_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          addr_d   = addr_in;
          len_d    = in_item_i.length;
          wr_d     = in_item_i.watch_writes;
          rd_d     = in_item_i.watch_reads;
          idx_d    = '0;
          taken_d  = 1'b0;
          status_d = ST_NONE;
          case (act_e'(in_item_i.action))
            ACT_ADD: begin
              state_d = S_ADD_FIND;
            end
            ACT_CLEAR: begin
              tbl_wr.clr = 1'b1;
              base_d     = '0;
              mask_d     = '0;
              trap_wr_d  = 1'b0;
              trap_rd_d  = 1'b0;
              enabled_d  = 1'b0;
              state_d    = S_FINISH;
            end
            ACT_CHECK: begin
              if (coarse_hit) begin
                status_d = ST_STEP;
                state_d  = S_CHK_SCAN;
              end else begin
                state_d = S_FINISH;
              end
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      S_ADD_FIND: begin
        if (slot_free || last_slot) begin
          if (slot_free) begin
            tbl_wr.en    = 1'b1;
            tbl_wr.idx   = idx_q;
            tbl_wr.start = addr_q;
            tbl_wr.stop  = stop_val;
            taken_d      = 1'b1;
          end
          idx_d   = '0;
          lo_d    = '1;
          hi_d    = '0;
          state_d = S_ADD_SPAN;
        end else begin
          idx_d = idx_q + SLOT_IDX_W'(1);
        end
      end

      S_ADD_SPAN: begin
        cmp_req.a0 = ADDR_W'(rd_start);
        cmp_req.b0 = lo_q;
        cmp_req.a1 = hi_q;
        cmp_req.b1 = rd_stop;
        if (!slot_free && cmp_rsp.lt0) begin
          lo_d = ADDR_W'(rd_start);
        end
        if ((rd_stop != '0) && cmp_rsp.lt1) begin
          hi_d = rd_stop;
        end
        if (last_slot) begin
          spread_d = '0;
          state_d  = S_ADD_SPREAD;
        end else begin
          idx_d = idx_q + SLOT_IDX_W'(1);
        end
      end

      S_ADD_SPREAD: begin
        // widen the don't-care field until the span fits; stops by itself
        // once spread is all ones
        cmp_req.a0 = lo_q | spread_q;
        cmp_req.b0 = hi_q;
        if (cmp_rsp.lt0) begin
          spread_d = {spread_q[ADDR_W-2:0], 1'b1};
        end else begin
          mask_d    = ~spread_q[PHYS_W-1:0];
          base_d    = lo_q[PHYS_W-1:0] & ~spread_q[PHYS_W-1:0];
          trap_wr_d = wr_q;
          trap_rd_d = rd_q;
          enabled_d = 1'b1;
          state_d   = S_FINISH;
        end
      end

      S_CHK_SCAN: begin
        cmp_req.a0 = ADDR_W'(addr_q);
        cmp_req.b0 = ADDR_W'(rd_start);
        cmp_req.a1 = rd_stop;
        cmp_req.b1 = ADDR_W'(addr_q);
        if (!slot_free && !cmp_rsp.lt0 && !cmp_rsp.lt1) begin
          status_d = ST_BREAK;
          state_d  = S_FINISH;
        end else if (last_slot) begin
          state_d = S_FINISH;
        end else begin
          idx_d = idx_q + SLOT_IDX_W'(1);
        end
      end

      S_FINISH: begin
        if (out_load) begin
          out_valid_d           = 1'b1;
          out_item_d.slot_taken = taken_q;
          out_item_d.status     = status_q;
          out_item_d.cover_base = base_q;
          out_item_d.cover_mask = mask_q;
          out_item_d.watching   = enabled_q;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      taken_q     <= 1'b0;
      status_q    <= ST_NONE;
      base_q      <= '0;
      mask_q      <= '0;
      trap_wr_q   <= 1'b0;
      trap_rd_q   <= 1'b0;
      enabled_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      taken_q     <= taken_d;
      status_q    <= status_d;
      base_q      <= base_d;
      mask_q      <= mask_d;
      trap_wr_q   <= trap_wr_d;
      trap_rd_q   <= trap_rd_d;
      enabled_q   <= enabled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    len_q      <= len_d;
    wr_q       <= wr_d;
    rd_q       <= rd_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    spread_q   <= spread_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// File: rtl/mrw_cmp_unit.sv
// Shared dual magnitude comparator used by the span, spread and check-scan steps.
`default_nettype none

module mrw_cmp_unit
  import mrw_pkg::*;
(
  input  cmp_req_t req_i,
  output cmp_rsp_t rsp_o
);

  assign rsp_o.lt0 = (req_i.a0 < req_i.b0);
  assign rsp_o.lt1 = (req_i.a1 < req_i.b1);

endmodule

`default_nettype wire

// File: rtl/mrw_slot_table.sv
// Range slot table: one write port, one read port, whole-table clear.
`default_nettype none

module mrw_slot_table
  import mrw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slot_wr_t              wr_i,
  input  logic [SLOT_IDX_W-1:0] rd_idx_i,
  output logic [PHYS_W-1:0]     rd_start_o,
  output logic [ADDR_W-1:0]     rd_stop_o
);

  logic [PHYS_W-1:0] start_q [SLOTS];
  logic [ADDR_W-1:0] stop_q  [SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        start_q[i] <= '0;
        stop_q[i]  <= '0;
      end
    end else if (wr_i.clr) begin
      for (int i = 0; i < SLOTS; i++) begin
        start_q[i] <= '0;
        stop_q[i]  <= '0;
      end
    end else if (wr_i.en) begin
      start_q[wr_i.idx] <= wr_i.start;
      stop_q[wr_i.idx]  <= wr_i.stop;
    end
  end

  assign rd_start_o = start_q[rd_idx_i];
  assign rd_stop_o  = stop_q[rd_idx_i];

endmodule

`default_nettype wire
